>>> sv/trsp_pkg.sv
// ============================================================================
// trsp_pkg
// Shared constants, types and helper functions of the time range sum parser.
// ============================================================================
`default_nettype none

package trsp_pkg;

    // Character codes.
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    // Signed weights of the four numbers of an entry, one byte each.
    localparam logic [31:0] WEIGHT_PACK = 32'h013C_FFC4;

    localparam int unsigned DAY_MINUTES  = 1440;
    localparam int unsigned HOUR_MINUTES = 60;

    localparam int unsigned INDEX_BITS   = 2;
    localparam int unsigned HOURS_BITS   = 27;
    localparam int unsigned MINUTES_BITS = 6;
    localparam int unsigned DAY_BITS     = 11;
    localparam int unsigned SUM_BITS     = 22;
    localparam int unsigned OUT_DATA_BITS = 40;

    localparam logic [INDEX_BITS-1:0] LAST_INDEX = 2'd3;

    // Reciprocals for the constant divisions by 1440 and by 60.
    localparam int unsigned DAY_RECIP_BITS   = 26;
    localparam logic [DAY_RECIP_BITS-1:0] DAY_RECIP = 26'd47721859;
    localparam int unsigned DAY_RECIP_SHIFT  = 36;
    localparam int unsigned HOUR_RECIP_BITS  = 15;
    localparam logic [HOUR_RECIP_BITS-1:0] HOUR_RECIP = 15'd17477;
    localparam int unsigned HOUR_RECIP_SHIFT = 20;

    typedef logic [7:0]              t_byte;
    typedef logic [HOURS_BITS-1:0]   t_hours;
    typedef logic [MINUTES_BITS-1:0] t_minutes;

    function automatic logic [7:0] weight_mag(input logic [INDEX_BITS-1:0] idx);
        logic [7:0] w;
        w = WEIGHT_PACK[8*idx +: 8];
        return w[7] ? 8'(~w + 8'd1) : w;
    endfunction

    function automatic logic weight_neg(input logic [INDEX_BITS-1:0] idx);
        return WEIGHT_PACK[8*idx + 7];
    endfunction

endpackage

`default_nettype wire

>>> sv/trsp_parser.sv
// ============================================================================
// trsp_parser
// Character parser: builds numbers from digit runs and forms the weighted
// sum of each entry, handing a completed entry on through a result register.
// ============================================================================
`default_nettype none

module trsp_parser #(
    parameter int unsigned NUMBER_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_byte_vld,
    output logic                   o_byte_rdy,
    input  trsp_pkg::t_byte        i_byte,
    output logic                   o_entry_vld,
    input  logic                   i_entry_rdy,
    output logic [NUMBER_BITS-1:0] o_entry
);
    import trsp_pkg::*;

    logic [INDEX_BITS-1:0]  r_idx;
    logic [NUMBER_BITS-1:0] r_num;
    logic                   r_in_num;
    logic [NUMBER_BITS-1:0] r_entry;
    logic                   r_e_vld;
    logic [NUMBER_BITS-1:0] r_e;

    logic                   acc;
    logic                   is_digit;
    logic                   is_newline;
    logic                   close;
    logic                   finish;
    logic [3:0]             digit;
    logic [NUMBER_BITS-1:0] n_num;
    logic [NUMBER_BITS-1:0] prod;
    logic [NUMBER_BITS-1:0] n_entry;

    assign o_byte_rdy  = !r_e_vld || i_entry_rdy;
    assign acc         = i_byte_vld && o_byte_rdy;
    assign is_digit    = (i_byte >= CHAR_ZERO) && (i_byte <= CHAR_NINE);
    assign is_newline  = (i_byte == CHAR_NEWLINE);
    assign close       = !is_digit && r_in_num;
    assign finish      = close && (r_idx == LAST_INDEX);
    assign digit       = 4'(i_byte - CHAR_ZERO);

    assign n_num   = (r_num << 3) + (r_num << 1) + NUMBER_BITS'(digit);
    assign prod    = NUMBER_BITS'(r_num * NUMBER_BITS'(weight_mag(r_idx)));
    assign n_entry = weight_neg(r_idx) ? (r_entry - prod) : (r_entry + prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_num    <= '0;
            r_in_num <= 1'b0;
            r_entry  <= '0;
            r_e_vld  <= 1'b0;
        end else begin
            if (o_byte_rdy) begin
                r_e_vld <= acc && finish;
            end
            if (acc) begin
                priority if (is_digit) begin
                    r_num    <= n_num;
                    r_in_num <= 1'b1;
                end else if (finish || is_newline) begin
                    r_idx    <= '0;
                    r_num    <= '0;
                    r_in_num <= 1'b0;
                    r_entry  <= '0;
                end else begin
                    if (close) begin
                        r_entry  <= n_entry;
                        r_num    <= '0;
                        r_in_num <= 1'b0;
                        r_idx    <= r_idx + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && finish) begin
            r_e <= n_entry;
        end
    end

    assign o_entry_vld = r_e_vld;
    assign o_entry     = r_e;

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && finish |=> (r_idx == '0) && !r_in_num && (r_entry == '0) && r_e_vld)
        else $error("entry not cleared after completion");

    a_digit_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && is_digit |=> r_in_num)
        else $error("digit did not open a number");

    a_newline_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && is_newline && !finish |=> (r_idx == '0) && (r_entry == '0) && !r_e_vld)
        else $error("newline did not abandon the entry");

endmodule

`default_nettype wire

>>> sv/trsp_total.sv
// ============================================================================
// trsp_total
// Elastic pipeline that reduces a completed entry modulo one day, adds it to
// the running total and keeps that total split into hours and minutes.
// ============================================================================
`default_nettype none

module trsp_total #(
    parameter int unsigned NUMBER_BITS = 32,
    parameter int unsigned TOTAL_BITS  = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_entry_vld,
    output logic                   o_entry_rdy,
    input  logic [NUMBER_BITS-1:0] i_entry,
    output logic                   o_res_vld,
    input  logic                   i_res_rdy,
    output trsp_pkg::t_hours       o_hours,
    output trsp_pkg::t_minutes     o_minutes
);
    import trsp_pkg::*;

    localparam int unsigned ChunkCount = (NUMBER_BITS + 7) / 8;
    localparam int unsigned HourBits   = (TOTAL_BITS > HOURS_BITS) ? TOTAL_BITS : HOURS_BITS;
    localparam int unsigned QuotBits   = SUM_BITS + DAY_RECIP_BITS - DAY_RECIP_SHIFT;
    localparam int unsigned HprodBits  = DAY_BITS + HOUR_RECIP_BITS;
    localparam int unsigned CarryBits  = HprodBits - HOUR_RECIP_SHIFT;

    function automatic logic [ChunkCount-1:0][DAY_BITS-1:0] chunk_residues();
        logic [ChunkCount-1:0][DAY_BITS-1:0] res;
        int unsigned r;
        int unsigned k;
        r = 1;
        for (k = 0; k < ChunkCount; k++) begin
            res[k] = DAY_BITS'(r);
            r = (r * 256) % DAY_MINUTES;
        end
        return res;
    endfunction

    function automatic logic [DAY_BITS-1:0] sign_lift();
        int unsigned r;
        int unsigned k;
        r = 1;
        for (k = 0; k < NUMBER_BITS; k++) begin
            r = (r * 2) % DAY_MINUTES;
        end
        return DAY_BITS'((DAY_MINUTES - r) % DAY_MINUTES);
    endfunction

    localparam logic [ChunkCount-1:0][DAY_BITS-1:0] ChunkRes = chunk_residues();
    localparam logic [DAY_BITS-1:0] SignLift = sign_lift();

    localparam logic [TOTAL_BITS:0] TotalSpan   = {1'b1, {TOTAL_BITS{1'b0}}};
    localparam logic [TOTAL_BITS:0] SpanHours   = TotalSpan / HOUR_MINUTES;
    localparam logic [MINUTES_BITS-1:0] SpanMinutes = MINUTES_BITS'(TotalSpan % HOUR_MINUTES);
    localparam logic [HourBits-1:0] WrapHours   = HourBits'(SpanHours + 1'b1);
    localparam logic [DAY_BITS-1:0] WrapLift    = DAY_BITS'(HOUR_MINUTES - SpanMinutes);

    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    logic                      r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [SUM_BITS-1:0]       r_sum;
    logic [SUM_BITS-1:0]       r_sum2;
    logic [QuotBits-1:0]       r_quot;
    logic [DAY_BITS-1:0]       r_add;
    logic [DAY_BITS-1:0]       r_add4;
    logic                      r_wrap;
    logic [TOTAL_BITS-1:0]     r_total;
    logic [HourBits-1:0]       r_hours;
    logic [MINUTES_BITS-1:0]   r_min;

    logic [ChunkCount*8-1:0]            w_pad;
    logic [SUM_BITS-1:0]                n_sum;
    logic [SUM_BITS+DAY_RECIP_BITS-1:0] n_prod;
    logic [SUM_BITS-1:0]                n_rem;
    logic [TOTAL_BITS:0]                n_total;
    logic [DAY_BITS-1:0]                n_span;
    logic [DAY_BITS-1:0]                n_sel;
    logic [HprodBits-1:0]               n_hprod;
    logic [CarryBits-1:0]               n_carry;
    logic [DAY_BITS-1:0]                n_min;
    logic [HourBits-1:0]                n_hours;

    assign rdy5        = !r_v5 || i_res_rdy;
    assign rdy4        = !r_v4 || rdy5;
    assign rdy3        = !r_v3 || rdy4;
    assign rdy2        = !r_v2 || rdy3;
    assign rdy1        = !r_v1 || rdy2;
    assign o_entry_rdy = rdy1;

    assign w_pad = (ChunkCount*8)'(i_entry);

    always_comb begin
        n_sum = i_entry[NUMBER_BITS-1] ? SUM_BITS'(SignLift) : '0;
        for (int i = 0; i < ChunkCount; i++) begin
            n_sum = n_sum + SUM_BITS'(w_pad[8*i +: 8]) * SUM_BITS'(ChunkRes[i]);
        end
    end

    assign n_prod  = (SUM_BITS+DAY_RECIP_BITS)'(r_sum)
                   * (SUM_BITS+DAY_RECIP_BITS)'(DAY_RECIP);
    assign n_rem   = r_sum2 - SUM_BITS'(r_quot) * SUM_BITS'(DAY_MINUTES);
    assign n_total = {1'b0, r_total} + (TOTAL_BITS+1)'(r_add);

    assign n_span  = DAY_BITS'(r_min) + r_add4;
    assign n_sel   = r_wrap ? (n_span + WrapLift) : n_span;
    assign n_hprod = HprodBits'(n_sel) * HprodBits'(HOUR_RECIP);
    assign n_carry = n_hprod[HprodBits-1:HOUR_RECIP_SHIFT];
    assign n_min   = n_sel - DAY_BITS'(n_carry) * DAY_BITS'(HOUR_MINUTES);
    assign n_hours = r_hours + HourBits'(n_carry) - (r_wrap ? WrapHours : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
            r_total <= '0;
            r_hours <= '0;
            r_min   <= '0;
        end else begin
            if (rdy1) r_v1 <= i_entry_vld;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
            if (rdy4 && r_v3) begin
                r_total <= n_total[TOTAL_BITS-1:0];
            end
            if (rdy5 && r_v4) begin
                r_hours <= n_hours;
                r_min   <= MINUTES_BITS'(n_min);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_entry_vld) begin
            r_sum <= n_sum;
        end
        if (rdy2 && r_v1) begin
            r_sum2 <= r_sum;
            r_quot <= n_prod[SUM_BITS+DAY_RECIP_BITS-1:DAY_RECIP_SHIFT];
        end
        if (rdy3 && r_v2) begin
            r_add <= DAY_BITS'(n_rem);
        end
        if (rdy4 && r_v3) begin
            r_add4 <= r_add;
            r_wrap <= n_total[TOTAL_BITS];
        end
    end

    assign o_res_vld = r_v5;
    assign o_hours   = r_hours[HOURS_BITS-1:0];
    assign o_minutes = r_min;

    a_day_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r_add < DAY_BITS'(DAY_MINUTES)))
        else $error("entry residue outside one day");

    a_minute_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> (r_min < MINUTES_BITS'(HOUR_MINUTES)))
        else $error("minutes outside one hour");

    a_entry_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_entry_vld && o_entry_rdy |=> r_v1)
        else $error("accepted entry lost at pipeline entry");

endmodule

`default_nettype wire

>>> sv/time_range_sum_parser.sv
// ============================================================================
// time_range_sum_parser
// Reads text one byte per beat and emits the running total of time ranges.
//
// The slave channel takes one character per beat. Digit runs form numbers;
// the four numbers of an entry ("H1:M1 - H2:M2") give end minus start in
// minutes, reduced into one day and added to a running total. A newline
// abandons a partial entry. The master channel carries one beat per
// completed entry with the total split into hours and minutes.
// Throughput is one byte per cycle while s_axis_tready is high. The byte that
// closes an entry yields its result on the master channel after it has passed
// the parser result register and the reduction and total pipeline.
// The pipeline is elastic, so bytes keep being taken while a result waits,
// until every stage holds an entry; then s_axis_tready falls until the
// receiver takes a beat. Reset clears the entry and the total to zero.
// ============================================================================
`default_nettype none

module time_range_sum_parser #(
    parameter int unsigned NUMBER_BITS = 32,
    parameter int unsigned TOTAL_BITS  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // text_byte [7:0]
    input  trsp_pkg::t_byte                      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // total_hours [26:0], total_minutes [32:27], zero [39:33]
    output logic [trsp_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata
);
    import trsp_pkg::*;

    logic                   entry_vld;
    logic                   entry_rdy;
    logic [NUMBER_BITS-1:0] entry;
    t_hours                 hours;
    t_minutes               minutes;

    trsp_parser #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_vld  (s_axis_tvalid),
        .o_byte_rdy  (s_axis_tready),
        .i_byte      (s_axis_tdata),
        .o_entry_vld (entry_vld),
        .i_entry_rdy (entry_rdy),
        .o_entry     (entry)
    );

    trsp_total #(
        .NUMBER_BITS (NUMBER_BITS),
        .TOTAL_BITS  (TOTAL_BITS)
    ) u_total (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry_vld (entry_vld),
        .o_entry_rdy (entry_rdy),
        .i_entry     (entry),
        .o_res_vld   (m_axis_tvalid),
        .i_res_rdy   (m_axis_tready),
        .o_hours     (hours),
        .o_minutes   (minutes)
    );

    assign m_axis_tdata = {(OUT_DATA_BITS-HOURS_BITS-MINUTES_BITS)'(0), minutes, hours};

endmodule

`default_nettype wire

>>> test/time_range_sum_parser_tb.sv
// ============================================================================
// time_range_sum_parser_tb
// Self-checking testbench of the time range sum parser.
//
// Text is fed one byte per beat on the slave channel: a short directed
// sequence first, then random time range entries with random digits, long
// digit runs, broken entries and stray bytes. Every accepted byte updates a
// model of the parser held in a small scoreboard, which queues the expected
// running totals; every beat on the master channel is checked against the
// oldest of them. Both channels idle and stall in random bursts, except for
// some stretches and the last part of the run.
// ============================================================================
`default_nettype none

module time_range_sum_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import trsp_pkg::*;

    typedef struct packed {
        t_hours   hours;
        t_minutes minutes;
    } t_total_beat;

    class total_scoreboard;
        logic [INDEX_BITS-1:0] num_idx;
        logic [31:0]           num_val;
        bit                    in_num;
        logic [31:0]           entry_sum;
        logic [31:0]           total;
        t_total_beat           expected_q[$];
        int unsigned           mismatches;

        function new();
            clear_entry();
            total      = '0;
            mismatches = 0;
        endfunction

        function void clear_entry();
            num_idx   = '0;
            num_val   = '0;
            in_num    = 1'b0;
            entry_sum = '0;
        endfunction

        function void note_byte(t_byte c);
            logic [7:0]  w;
            int          sgn;
            int          day;
            t_total_beat beat;
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                num_val = num_val * 32'd10 + {24'd0, t_byte'(c - CHAR_ZERO)};
                in_num  = 1'b1;
                return;
            end
            if (in_num) begin
                w         = WEIGHT_PACK[8*num_idx +: 8];
                entry_sum = entry_sum + {{24{w[7]}}, w} * num_val;
                num_val   = '0;
                in_num    = 1'b0;
                if (num_idx == LAST_INDEX) begin
                    sgn = $signed(entry_sum);
                    day = sgn % int'(DAY_MINUTES);
                    if (day < 0) begin
                        day += int'(DAY_MINUTES);
                    end
                    total        = total + 32'(day);
                    beat.hours   = t_hours'(total / HOUR_MINUTES);
                    beat.minutes = t_minutes'(total % HOUR_MINUTES);
                    expected_q.push_back(beat);
                    clear_entry();
                    return;
                end
                num_idx = num_idx + 1'b1;
            end
            if (c == CHAR_NEWLINE) begin
                clear_entry();
            end
        endfunction

        function void check_total(logic [OUT_DATA_BITS-1:0] data);
            t_total_beat exp_beat;
            t_hours      act_hours;
            t_minutes    act_minutes;
            logic [6:0]  act_pad;
            act_hours   = data[HOURS_BITS-1:0];
            act_minutes = data[HOURS_BITS +: MINUTES_BITS];
            act_pad     = data[OUT_DATA_BITS-1:HOURS_BITS+MINUTES_BITS];
            if (expected_q.size() == 0) begin
                if (mismatches < 10) begin
                    $display("%0t: unexpected result beat, hours %0d minutes %0d",
                             $realtime, act_hours, act_minutes);
                end
                mismatches++;
                return;
            end
            exp_beat = expected_q.pop_front();
            if (act_hours !== exp_beat.hours || act_minutes !== exp_beat.minutes ||
                act_pad !== '0) begin
                if (mismatches < 10) begin
                    $display("%0t: mismatch, expected %0d h %0d min, got %0d h %0d min pad %0h",
                             $realtime, exp_beat.hours, exp_beat.minutes,
                             act_hours, act_minutes, act_pad);
                end
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    t_byte                    s_axis_tdata = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;

    total_scoreboard sb = new();
    bit              idle_on = 1'b1;
    int unsigned     bytes_sent = 0;

    time_range_sum_parser DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_byte(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_total(m_axis_tdata);
            end
        end
    end

    initial begin
        int unsigned hold;
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 3) == 0) begin
                hold = $urandom_range(1, 16);
                m_axis_tready <= 1'b0;
                repeat (hold - 1) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input t_byte b);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(t_byte'(s[i]));
        end
    endtask

    function automatic t_byte pick_separator();
        t_byte b;
        case ($urandom_range(0, 3))
            0: b = ":";
            1: b = " ";
            2: b = "-";
            default: begin
                do begin
                    b = t_byte'($urandom_range(0, 255));
                end while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == CHAR_NEWLINE);
            end
        endcase
        return b;
    endfunction

    task automatic send_number();
        int unsigned digits;
        digits = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 2);
        repeat (digits) begin
            send_byte(CHAR_ZERO + t_byte'($urandom_range(0, 9)));
        end
    endtask

    task automatic send_entry();
        int unsigned numbers;
        numbers = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 4;
        for (int k = 0; k < numbers; k++) begin
            send_number();
            if (k < 3) begin
                send_byte(pick_separator());
                if ($urandom_range(0, 5) == 0) begin
                    send_byte(pick_separator());
                end
            end
        end
        if (numbers < 4 || $urandom_range(0, 9) < 7) begin
            send_byte(CHAR_NEWLINE);
        end else begin
            send_byte(pick_separator());
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Lone separator, a negative range closed by an all-ones byte, an
        // abandoned entry, and a range one minute short of a day closed by the newline.
        send_byte(8'h00);
        send_text("9:9-0:0");
        send_byte(8'hFF);
        send_text("1:2-3\n");
        send_text("0:0-23:59\n");

        while (bytes_sent < 900) begin
            idle_on = (bytes_sent < 700) && ((bytes_sent / 100) % 3 != 2);
            if ($urandom_range(0, 9) == 0) begin
                send_byte(t_byte'($urandom_range(0, 255)));
            end else begin
                send_entry();
            end
        end
        idle_on = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
